// ----- hw/rtl/cwrp_pkg.sv -----
// Shared types, sizes, codes and cold-value function for the replacement store.
`timescale 1ns / 1ps

package cwrp_pkg;

    // Cache geometry
    localparam int WAYS      = 8;
    localparam int NUM_SETS  = 64;
    localparam int WAY_BITS  = 3;
    localparam int SET_BITS  = 6;
    localparam int RANK_BITS = WAY_BITS;
    localparam int NODE_W    = WAY_BITS + 1;
    localparam int STATE_W   = WAYS * RANK_BITS;

    // APB register file
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REGIDX_W  = PADDR_W - 2;

    typedef logic [STATE_W-1:0]  t_state;
    typedef logic [WAY_BITS-1:0] t_way;
    typedef logic [SET_BITS-1:0] t_set;
    typedef logic [REGIDX_W-1:0] t_regidx;

    typedef enum logic [1:0] {
        POL_PLRU    = 2'd0,
        POL_LRU     = 2'd1,
        POL_FIFO    = 2'd2,
        POL_STRIDE3 = 2'd3
    } t_policy;

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_TOUCH = 1'b1;

    localparam t_regidx REG_POLICY = t_regidx'(0);

    // Pointer steps for the two pointer policies
    localparam t_way FIFO_STEP    = t_way'(1);
    localparam t_way STRIDE3_STEP = t_way'(3);

    // Request as seen by the update logic
    typedef struct packed {
        logic cmd;
        t_way way;
    } t_req;

    // State of a set straight after a policy change
    function automatic t_state cold_state(t_policy pol);
        t_state s;
        s = '0;
        if (pol == POL_LRU) begin
            for (int i = 0; i < WAYS; i++) begin
                s[i*RANK_BITS +: RANK_BITS] = RANK_BITS'(WAYS - 1 - i);
            end
        end
        return s;
    endfunction

endpackage

// ----- hw/rtl/cwrp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module cwrp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/cwrp_policy.sv -----
// Next-state and victim logic for the four replacement policies.
`timescale 1ns / 1ps

module cwrp_policy (
    input  cwrp_pkg::t_policy i_policy,
    input  cwrp_pkg::t_req    i_req,
    input  cwrp_pkg::t_state  i_state,
    output cwrp_pkg::t_state  o_state,
    output cwrp_pkg::t_way    o_victim
);

    always_comb begin
        cwrp_pkg::t_state                   s;
        logic [cwrp_pkg::WAYS-1:1]          tr;
        logic [cwrp_pkg::NODE_W-1:0]        node;
        logic [cwrp_pkg::WAY_BITS-1:0]      parent;
        logic [cwrp_pkg::RANK_BITS-1:0]     hit;
        logic [cwrp_pkg::RANK_BITS-1:0]     r;
        cwrp_pkg::t_way                     v;

        s      = i_state;
        tr     = i_state[cwrp_pkg::WAYS-2:0];
        node   = '0;
        parent = '0;
        hit    = i_state[i_req.way*cwrp_pkg::RANK_BITS +: cwrp_pkg::RANK_BITS];
        r      = '0;
        v      = '0;

        // Update on a touch
        case (i_policy)
            cwrp_pkg::POL_PLRU: begin
                if (i_req.cmd == cwrp_pkg::CMD_TOUCH) begin
                    // walk leaf to root, each node points away from the touched way
                    node = {1'b1, i_req.way};
                    for (int l = 0; l < cwrp_pkg::WAY_BITS; l++) begin
                        parent     = node[cwrp_pkg::NODE_W-1:1];
                        tr[parent] = ~node[0];
                        node       = {1'b0, parent};
                    end
                    s[cwrp_pkg::WAYS-2:0] = tr;
                end
            end
            cwrp_pkg::POL_LRU: begin
                if (i_req.cmd == cwrp_pkg::CMD_TOUCH) begin
                    for (int i = 0; i < cwrp_pkg::WAYS; i++) begin
                        r = i_state[i*cwrp_pkg::RANK_BITS +: cwrp_pkg::RANK_BITS];
                        if (cwrp_pkg::WAY_BITS'(i) == i_req.way) begin
                            s[i*cwrp_pkg::RANK_BITS +: cwrp_pkg::RANK_BITS] = '0;
                        end else if (r < hit) begin
                            s[i*cwrp_pkg::RANK_BITS +: cwrp_pkg::RANK_BITS] =
                                r + cwrp_pkg::RANK_BITS'(1);
                        end
                    end
                end
            end
            cwrp_pkg::POL_FIFO: begin
                if (i_req.cmd == cwrp_pkg::CMD_TOUCH) begin
                    // pointer wraps at the way count, upper bits stay clear
                    s = '0;
                    s[cwrp_pkg::WAY_BITS-1:0] =
                        i_state[cwrp_pkg::WAY_BITS-1:0] + cwrp_pkg::FIFO_STEP;
                end
            end
            default: begin
                if (i_req.cmd == cwrp_pkg::CMD_TOUCH) begin
                    s = '0;
                    s[cwrp_pkg::WAY_BITS-1:0] =
                        i_state[cwrp_pkg::WAY_BITS-1:0] + cwrp_pkg::STRIDE3_STEP;
                end
            end
        endcase

        // Victim of the updated state
        case (i_policy)
            cwrp_pkg::POL_PLRU: begin
                node = cwrp_pkg::NODE_W'(1);
                for (int l = 0; l < cwrp_pkg::WAY_BITS; l++) begin
                    node = {node[cwrp_pkg::WAY_BITS-1:0],
                            tr[node[cwrp_pkg::WAY_BITS-1:0]]};
                end
                v = node[cwrp_pkg::WAY_BITS-1:0];
            end
            cwrp_pkg::POL_LRU: begin
                // highest way holding the oldest rank, way 0 if none does
                for (int i = 0; i < cwrp_pkg::WAYS; i++) begin
                    if (s[i*cwrp_pkg::RANK_BITS +: cwrp_pkg::RANK_BITS] ==
                        cwrp_pkg::RANK_BITS'(cwrp_pkg::WAYS - 1)) begin
                        v = cwrp_pkg::WAY_BITS'(i);
                    end
                end
            end
            default: begin
                v = s[cwrp_pkg::WAY_BITS-1:0];
            end
        endcase

        o_state  = s;
        o_victim = v;
    end

endmodule

// ----- hw/rtl/cache_way_replacement_policy_top.sv -----
// Top level of the per-set cache replacement store.
`timescale 1ns / 1ps

// Replacement state store for an 8-way, 64-set cache.
// Item channel: drive i_cmd, i_set_index, i_way with start high; the item is
// taken at a clock edge where start is high and busy is low. busy stays low,
// so an item may be issued every cycle.
// Each item returns exactly one result: o_victim with o_valid high for one
// cycle, after stage 1 and the result register. Results come out in item order.
// The receiver cannot stall the result; it must take o_valid when it comes.
// Set state sits in a 64 x 24 synchronous RAM: an item reads its set at the
// accepting edge, updates it in the next cycle and writes it back at the end
// of that cycle. A forwarding register covers the item right behind it.
// Configuration: one APB register (policy, byte address 0). Writing it puts
// every set back to the new policy's cold value at once through a bank of
// per-set valid flags; a set whose flag is clear reads as the cold value.
// Reset (synchronous, active low) selects tree pseudo LRU and clears all
// valid flags, so no clearing sweep is needed and items are taken at once.

module cache_way_replacement_policy_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // item channel
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cmd,
    input  logic [cwrp_pkg::SET_BITS-1:0] i_set_index,
    input  logic [cwrp_pkg::WAY_BITS-1:0] i_way,

    // result channel
    output logic                         o_valid,
    output logic [cwrp_pkg::WAY_BITS-1:0] o_victim,

    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cwrp_pkg::PADDR_W-1:0] paddr,
    input  logic [cwrp_pkg::PDATA_W-1:0] pwdata,
    output logic [cwrp_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    logic                      w_accept;
    logic                      w_cfg_wr;
    logic                      w_pol_wr;
    logic                      w_fwd_hit;
    cwrp_pkg::t_state          w_rdata;
    cwrp_pkg::t_state          w_cur_state;
    cwrp_pkg::t_state          w_new_state;
    cwrp_pkg::t_way            w_victim;

    cwrp_pkg::t_policy         r_policy;
    logic [cwrp_pkg::NUM_SETS-1:0] r_set_vld;

    logic                      r_s1_vld;
    cwrp_pkg::t_req            r_s1_req;
    cwrp_pkg::t_set            r_s1_set;

    logic                      r_fwd_vld;
    cwrp_pkg::t_set            r_fwd_set;
    cwrp_pkg::t_state          r_fwd_data;

    logic                      r_out_vld;
    cwrp_pkg::t_way            r_out_victim;

    // Handshakes
    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_pol_wr = w_cfg_wr &&
                      (paddr[cwrp_pkg::PADDR_W-1:2] == cwrp_pkg::REG_POLICY);

    // Register read-back
    always_comb begin
        prdata = '0;
        if (paddr[cwrp_pkg::PADDR_W-1:2] == cwrp_pkg::REG_POLICY) begin
            prdata = cwrp_pkg::PDATA_W'(r_policy);
        end
    end

    // Policy register and per-set valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy  <= cwrp_pkg::POL_PLRU;
            r_set_vld <= '0;
        end else if (w_pol_wr) begin
            r_policy  <= cwrp_pkg::t_policy'(pwdata[1:0]);
            r_set_vld <= '0;
        end else if (r_s1_vld) begin
            r_set_vld[r_s1_set] <= 1'b1;
        end
    end

    // Set state memory
    cwrp_ram #(
        .WIDTH (cwrp_pkg::STATE_W),
        .DEPTH (cwrp_pkg::NUM_SETS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_set),
        .i_wdata (w_new_state),
        .i_re    (w_accept),
        .i_raddr (i_set_index),
        .o_rdata (w_rdata)
    );

    // Stage 1: item waits for its read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_req <= '{cmd: i_cmd, way: i_way};
            r_s1_set <= i_set_index;
        end
    end

    // Pick the current set state: forwarded, cold, or from the RAM
    assign w_fwd_hit = r_fwd_vld && (r_fwd_set == r_s1_set);

    always_comb begin
        if (w_fwd_hit) begin
            w_cur_state = r_fwd_data;
        end else if (!r_set_vld[r_s1_set]) begin
            w_cur_state = cwrp_pkg::cold_state(r_policy);
        end else begin
            w_cur_state = w_rdata;
        end
    end

    cwrp_policy u_policy (
        .i_policy (r_policy),
        .i_req    (r_s1_req),
        .i_state  (w_cur_state),
        .o_state  (w_new_state),
        .o_victim (w_victim)
    );

    // Forwarding of the last write-back to the next item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (w_pol_wr) begin
            r_fwd_vld <= 1'b0;
        end else begin
            r_fwd_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_fwd_set  <= r_s1_set;
            r_fwd_data <= w_new_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_out_victim <= w_victim;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_victim = r_out_victim;

    // Every accepted item gives a result through stage 1 and the result register
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##2 o_valid)
        else $error("result missing two cycles after accepted item");

    // A query leaves the set state as it was
    a_query_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_req.cmd == cwrp_pkg::CMD_QUERY) |-> (w_new_state == w_cur_state))
        else $error("query changed set state");

    // A written-back set is marked valid unless the policy was rewritten
    a_set_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !w_pol_wr) |=> r_set_vld[$past(r_s1_set)])
        else $error("written set not marked valid");

    // FIFO touch moves the victim on by one way
    a_fifo_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_policy == cwrp_pkg::POL_FIFO && r_s1_req.cmd == cwrp_pkg::CMD_TOUCH)
        |-> (w_victim == cwrp_pkg::t_way'(w_cur_state[cwrp_pkg::WAY_BITS-1:0]
                                           + cwrp_pkg::FIFO_STEP)))
        else $error("fifo pointer did not advance");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the per-set cache replacement store.
`timescale 1ns / 1ps

module tb;

    localparam int PHASE_ITEMS = 125;
    localparam int QUIET_LIMIT = 1000;
    localparam int TAIL_CYCLES = 8;

    typedef struct {
        logic           cmd;
        cwrp_pkg::t_set set_idx;
        cwrp_pkg::t_way way;
    } t_cache_req;

    typedef struct {
        cwrp_pkg::t_set set_idx;
        cwrp_pkg::t_way victim;
    } t_victim_exp;

    // DUT connections
    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         start       = 1'b0;
    logic                         busy;
    logic                         i_cmd       = cwrp_pkg::CMD_QUERY;
    cwrp_pkg::t_set               i_set_index = '0;
    cwrp_pkg::t_way               i_way       = '0;
    logic                         o_valid;
    cwrp_pkg::t_way               o_victim;
    logic                         psel        = 1'b0;
    logic                         penable     = 1'b0;
    logic                         pwrite      = 1'b0;
    logic [cwrp_pkg::PADDR_W-1:0] paddr       = '0;
    logic [cwrp_pkg::PDATA_W-1:0] pwdata      = '0;
    logic [cwrp_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    // Predictor copy of the policy and of every set's state word
    cwrp_pkg::t_policy cur_policy;
    cwrp_pkg::t_state  set_word [cwrp_pkg::NUM_SETS];

    t_cache_req  pending_reqs[$];
    t_victim_exp expected_victims[$];
    int          err_count  = 0;
    int          gap_left   = 0;
    int          burst_left = 0;
    int          quiet_cycles = 0;

    cache_way_replacement_policy_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_set_index (i_set_index),
        .i_way       (i_way),
        .o_valid     (o_valid),
        .o_victim    (o_victim),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // State word of a set straight after a policy write
    function automatic cwrp_pkg::t_state cold_word(cwrp_pkg::t_policy p);
        cwrp_pkg::t_state s;
        s = '0;
        if (p == cwrp_pkg::POL_LRU) begin
            for (int i = 0; i < cwrp_pkg::WAYS; i++) begin
                s[i*cwrp_pkg::RANK_BITS +: cwrp_pkg::RANK_BITS] =
                    cwrp_pkg::RANK_BITS'(cwrp_pkg::WAYS - 1 - i);
            end
        end
        return s;
    endfunction

    // Victim way held in a state word
    function automatic cwrp_pkg::t_way victim_for(cwrp_pkg::t_state s,
                                                  cwrp_pkg::t_policy p);
        int             node;
        cwrp_pkg::t_way v;
        v = '0;
        case (p)
            cwrp_pkg::POL_PLRU: begin
                node = 1;
                while (node < cwrp_pkg::WAYS) node = 2 * node + int'(s[node-1]);
                v = cwrp_pkg::t_way'(node - cwrp_pkg::WAYS);
            end
            cwrp_pkg::POL_LRU: begin
                // highest way holding the top rank; 0 if none does
                for (int i = 0; i < cwrp_pkg::WAYS; i++) begin
                    if (s[i*cwrp_pkg::RANK_BITS +: cwrp_pkg::RANK_BITS] ==
                        cwrp_pkg::RANK_BITS'(cwrp_pkg::WAYS - 1)) v = cwrp_pkg::t_way'(i);
                end
            end
            default: v = s[cwrp_pkg::WAY_BITS-1:0];
        endcase
        return v;
    endfunction

    // State word after a touch of way w
    function automatic cwrp_pkg::t_state state_after_touch(cwrp_pkg::t_state s,
                                                           cwrp_pkg::t_way w,
                                                           cwrp_pkg::t_policy p);
        cwrp_pkg::t_state                n;
        int                              node;
        int                              parent;
        logic [cwrp_pkg::RANK_BITS-1:0]  hit;
        logic [cwrp_pkg::RANK_BITS-1:0]  r;
        n = s;
        case (p)
            cwrp_pkg::POL_PLRU: begin
                // every node on the path points away from the touched way
                node = cwrp_pkg::WAYS + int'(w);
                while (node > 1) begin
                    parent = node / 2;
                    n[parent-1] = (node == 2 * parent);
                    node = parent;
                end
            end
            cwrp_pkg::POL_LRU: begin
                hit = s[w*cwrp_pkg::RANK_BITS +: cwrp_pkg::RANK_BITS];
                for (int i = 0; i < cwrp_pkg::WAYS; i++) begin
                    r = s[i*cwrp_pkg::RANK_BITS +: cwrp_pkg::RANK_BITS];
                    if (i == int'(w)) n[i*cwrp_pkg::RANK_BITS +: cwrp_pkg::RANK_BITS] = '0;
                    else if (r < hit)
                        n[i*cwrp_pkg::RANK_BITS +: cwrp_pkg::RANK_BITS] = r + 1'b1;
                end
            end
            cwrp_pkg::POL_FIFO: begin
                n = '0;
                n[cwrp_pkg::WAY_BITS-1:0] = s[cwrp_pkg::WAY_BITS-1:0] + cwrp_pkg::FIFO_STEP;
            end
            default: begin
                n = '0;
                n[cwrp_pkg::WAY_BITS-1:0] =
                    s[cwrp_pkg::WAY_BITS-1:0] + cwrp_pkg::STRIDE3_STEP;
            end
        endcase
        return n;
    endfunction

    // Item driver: predicts on acceptance, then issues the next item or idles
    always @(posedge i_clk) begin : drive_items
        t_cache_req  r;
        t_victim_exp e;
        logic        nxt;
        int          roll;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            nxt = start;
            if (start && !busy) begin
                if (i_cmd == cwrp_pkg::CMD_TOUCH) begin
                    set_word[i_set_index] = state_after_touch(set_word[i_set_index], i_way,
                                                              cur_policy);
                end
                e.set_idx = i_set_index;
                e.victim  = victim_for(set_word[i_set_index], cur_policy);
                expected_victims = {expected_victims, e};
                nxt = 1'b0;
            end
            if (!nxt) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() > 0) begin
                    r = pending_reqs.pop_front();
                    i_cmd       <= r.cmd;
                    i_set_index <= r.set_idx;
                    i_way       <= r.way;
                    nxt = 1'b1;
                    // mostly back to back, some short gaps, a few long ones
                    if (burst_left > 0) begin
                        burst_left--;
                        gap_left = 0;
                    end else begin
                        roll = $urandom_range(0, 99);
                        if (roll < 3) begin
                            burst_left = $urandom_range(20, 60);
                            gap_left   = 0;
                        end else if (roll < 65) gap_left = 0;
                        else if (roll < 90) gap_left = $urandom_range(1, 3);
                        else if (roll < 98) gap_left = $urandom_range(4, 12);
                        else gap_left = $urandom_range(20, 40);
                    end
                end
            end
            start <= nxt;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin : check_victims
        t_victim_exp e;
        if (i_rst_n && o_valid) begin
            if (expected_victims.size() == 0) begin
                $display("%0t: unexpected result: expected none, got victim %0d",
                         $time, o_victim);
                err_count++;
            end else begin
                e = expected_victims.pop_front();
                if (o_victim !== e.victim) begin
                    $display("%0t: victim mismatch in set %0d: expected %0d, got %0d",
                             $time, e.set_idx, e.victim, o_victim);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no traffic at all
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (start && !busy) || o_valid || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout after %0d quiet cycles", $time, quiet_cycles);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_req(input logic cmd, input int set_idx, input int way);
        t_cache_req r;
        r.cmd     = cmd;
        r.set_idx = cwrp_pkg::t_set'(set_idx);
        r.way     = cwrp_pkg::t_way'(way);
        pending_reqs = {pending_reqs, r};
    endtask

    // Wait until every item has gone in and every result has come back
    task automatic drain();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || start || expected_victims.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic cfg_write(input logic [cwrp_pkg::PADDR_W-1:0] addr,
                             input logic [cwrp_pkg::PDATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // only the policy register exists; the write puts every set back to cold
        if (cwrp_pkg::t_regidx'(addr[cwrp_pkg::PADDR_W-1:2]) == cwrp_pkg::REG_POLICY) begin
            cur_policy = cwrp_pkg::t_policy'(data[1:0]);
            for (int i = 0; i < cwrp_pkg::NUM_SETS; i++) set_word[i] = cold_word(cur_policy);
        end
    endtask

    task automatic cfg_check_policy();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {cwrp_pkg::REG_POLICY, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[1:0] !== cur_policy) begin
            $display("%0t: policy read mismatch: expected %0d, got %0d",
                     $time, cur_policy, prdata[1:0]);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stimulus sequence
    initial begin : stimulus
        t_cache_req                   r;
        cwrp_pkg::t_set               hot [4];
        logic [cwrp_pkg::PDATA_W-1:0] d;
        cwrp_pkg::t_policy            phase_pol [9];

        phase_pol = '{cwrp_pkg::POL_PLRU, cwrp_pkg::POL_LRU, cwrp_pkg::POL_LRU,
                      cwrp_pkg::POL_FIFO, cwrp_pkg::POL_STRIDE3, cwrp_pkg::POL_PLRU,
                      cwrp_pkg::POL_STRIDE3, cwrp_pkg::POL_LRU, cwrp_pkg::POL_FIFO};
        cur_policy = cwrp_pkg::POL_PLRU;
        for (int i = 0; i < cwrp_pkg::NUM_SETS; i++) set_word[i] = cold_word(cwrp_pkg::POL_PLRU);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: tree pseudo LRU from reset, edge sets and ways
        push_req(cwrp_pkg::CMD_QUERY, 0, 0);
        push_req(cwrp_pkg::CMD_QUERY, 63, 7);
        push_req(cwrp_pkg::CMD_TOUCH, 0, 0);
        push_req(cwrp_pkg::CMD_TOUCH, 0, 7);
        push_req(cwrp_pkg::CMD_TOUCH, 0, 4);
        push_req(cwrp_pkg::CMD_TOUCH, 0, 3);
        push_req(cwrp_pkg::CMD_QUERY, 0, 5);
        push_req(cwrp_pkg::CMD_TOUCH, 63, 5);
        push_req(cwrp_pkg::CMD_TOUCH, 63, 2);
        push_req(cwrp_pkg::CMD_TOUCH, 63, 6);
        push_req(cwrp_pkg::CMD_TOUCH, 63, 1);
        push_req(cwrp_pkg::CMD_QUERY, 63, 0);
        push_req(cwrp_pkg::CMD_TOUCH, 42, 7);
        push_req(cwrp_pkg::CMD_TOUCH, 42, 7);
        push_req(cwrp_pkg::CMD_QUERY, 21, 2);
        push_req(cwrp_pkg::CMD_TOUCH, 21, 0);
        drain();
        cfg_check_policy();

        // directed: true LRU, touching the oldest, the newest and the same way twice
        cfg_write({cwrp_pkg::REG_POLICY, 2'b00}, {30'd0, cwrp_pkg::POL_LRU});
        push_req(cwrp_pkg::CMD_QUERY, 0, 0);
        push_req(cwrp_pkg::CMD_TOUCH, 5, 7);
        push_req(cwrp_pkg::CMD_TOUCH, 5, 7);
        push_req(cwrp_pkg::CMD_TOUCH, 5, 0);
        push_req(cwrp_pkg::CMD_TOUCH, 5, 3);
        push_req(cwrp_pkg::CMD_TOUCH, 5, 3);
        push_req(cwrp_pkg::CMD_QUERY, 5, 1);
        push_req(cwrp_pkg::CMD_TOUCH, 40, 1);
        drain();

        // random phases under changing policies
        foreach (phase_pol[p]) begin
            if (p % 2 == 1) begin
                // a write beyond the only register is ignored
                d = $urandom();
                cfg_write({~cwrp_pkg::REG_POLICY, 2'b00}, d);
            end
            d = $urandom();
            d[1:0] = phase_pol[p];
            cfg_write({cwrp_pkg::REG_POLICY, 2'b00}, d);
            cfg_check_policy();
            for (int h = 0; h < 4; h++) hot[h] = cwrp_pkg::t_set'($urandom());
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r.cmd     = ($urandom_range(0, 99) < 65) ? cwrp_pkg::CMD_TOUCH
                                                         : cwrp_pkg::CMD_QUERY;
                r.set_idx = ($urandom_range(0, 99) < 70) ? hot[$urandom_range(0, 3)]
                                                         : cwrp_pkg::t_set'($urandom());
                r.way     = cwrp_pkg::t_way'($urandom());
                pending_reqs = {pending_reqs, r};
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_victims.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_victims.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
